FILE: src/rbt_pkg.sv
// shared types, codes and constants of the resource barrier tracker
`default_nettype none

package rbt_pkg;

	// table geometry
	localparam int MAX_RESOURCES = 64;
	localparam int IDX_W         = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;

	// fixed field widths
	localparam int MODE_W   = 2;
	localparam int RES_W    = 6;
	localparam int LAYOUT_W = 31;
	localparam int MASK_W   = 64;

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	// mode codes on the input word
	localparam logic [MODE_W-1:0] MODE_DECLARE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ACCESS  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_READ    = 2'd2;

	// pipeline and layout constants
	localparam logic [MASK_W-1:0]   STAGE_TOP_OF_PIPE = 64'd1;
	localparam logic [MASK_W-1:0]   STAGE_NONE        = 64'd0;
	localparam logic [MASK_W-1:0]   ACCESS_NONE       = 64'd0;
	localparam logic [LAYOUT_W-1:0] LAYOUT_UNDEFINED  = 31'd0;

	// operation after classification
	typedef enum logic [1:0] {
		OP_NOP,
		OP_DECLARE,
		OP_ACCESS,
		OP_READ
	} op_t;

	// back end sequencer states
	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	// classified word held in the queue
	typedef struct packed {
		op_t                 op;
		logic [RES_W-1:0]    resource;
		logic                is_texture;
		logic [LAYOUT_W-1:0] layout;
		logic [MASK_W-1:0]   stage_mask;
		logic [MASK_W-1:0]   access_mask;
		logic                is_write;
	} item_t;

	// one resource table entry
	typedef struct packed {
		logic [MASK_W-1:0]   last_stage;
		logic [MASK_W-1:0]   last_access;
		logic [LAYOUT_W-1:0] cur_layout;
		logic                was_written;
		logic                texture_kind;
	} entry_t;

	// result word
	typedef struct packed {
		logic                barrier_needed;
		logic [RES_W-1:0]    barrier_resource;
		logic [MASK_W-1:0]   src_stage;
		logic [MASK_W-1:0]   dst_stage;
		logic [MASK_W-1:0]   src_access;
		logic [MASK_W-1:0]   dst_access;
		logic [LAYOUT_W-1:0] old_layout;
		logic [LAYOUT_W-1:0] new_layout;
		logic [LAYOUT_W-1:0] final_layout;
	} result_t;

endpackage

`default_nettype wire

FILE: src/resource_barrier_tracker_core.sv
// Resource barrier tracker: per-resource hazard table that decides pipeline barriers.
// Each input word declares a resource, records one access to it, or reads back its
// current layout, and each word gives exactly one result word. A front end classifies
// incoming words into a two-word queue; a back end takes one word at a time, finishing
// it before it pops the next: in the idle state it pops the word and does the registered
// read of the 64-entry resource table, and in the execute state it updates the entry
// and loads the result register, so each word makes a single read-then-write pass. The
// result register is reloaded in the cycle its previous word drains, so a stalled result
// holds the back end, while the queue keeps accepting words until both slots are full.
// Valid bits make every entry read as empty from reset, so no clearing pass is needed.
`default_nettype none

module resource_barrier_tracker_core (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           in_valid,
	output logic                          in_stall,
	input  wire  [rbt_pkg::MODE_W-1:0]    mode,
	input  wire  [rbt_pkg::RES_W-1:0]     resource,
	input  wire                           is_texture,
	input  wire  [rbt_pkg::LAYOUT_W-1:0]  layout,
	input  wire  [rbt_pkg::MASK_W-1:0]    stage_mask,
	input  wire  [rbt_pkg::MASK_W-1:0]    access_mask,
	input  wire                           is_write,
	output logic                          out_valid,
	input  wire                           out_stall,
	output logic                          barrier_needed,
	output logic [rbt_pkg::RES_W-1:0]     barrier_resource,
	output logic [rbt_pkg::MASK_W-1:0]    src_stage,
	output logic [rbt_pkg::MASK_W-1:0]    dst_stage,
	output logic [rbt_pkg::MASK_W-1:0]    src_access,
	output logic [rbt_pkg::MASK_W-1:0]    dst_access,
	output logic [rbt_pkg::LAYOUT_W-1:0]  old_layout,
	output logic [rbt_pkg::LAYOUT_W-1:0]  new_layout,
	output logic [rbt_pkg::LAYOUT_W-1:0]  final_layout
);

	logic             q_valid;
	logic             q_pop;
	rbt_pkg::item_t   q_item;
	rbt_pkg::result_t res;

	// classification and queue
	rbt_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.resource    (resource),
		.is_texture  (is_texture),
		.layout      (layout),
		.stage_mask  (stage_mask),
		.access_mask (access_mask),
		.is_write    (is_write),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop)
	);

	// table update and result
	rbt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res)
	);

	// result word onto its ports
	assign barrier_needed   = res.barrier_needed;
	assign barrier_resource = res.barrier_resource;
	assign src_stage        = res.src_stage;
	assign dst_stage        = res.dst_stage;
	assign src_access       = res.src_access;
	assign dst_access       = res.dst_access;
	assign old_layout       = res.old_layout;
	assign new_layout       = res.new_layout;
	assign final_layout     = res.final_layout;

endmodule

`default_nettype wire

FILE: src/rbt_front.sv
// front end: accepts input words, classifies them and queues them for the back end
`default_nettype none

module rbt_front (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           in_valid,
	output logic                          in_stall,
	input  wire  [rbt_pkg::MODE_W-1:0]    mode,
	input  wire  [rbt_pkg::RES_W-1:0]     resource,
	input  wire                           is_texture,
	input  wire  [rbt_pkg::LAYOUT_W-1:0]  layout,
	input  wire  [rbt_pkg::MASK_W-1:0]    stage_mask,
	input  wire  [rbt_pkg::MASK_W-1:0]    access_mask,
	input  wire                           is_write,
	output logic                          q_valid,
	output rbt_pkg::item_t                q_item,
	input  wire                           q_pop
);

	rbt_pkg::item_t              item_in;
	rbt_pkg::item_t              q_mem_q [rbt_pkg::QUEUE_DEPTH];
	logic [rbt_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [rbt_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [rbt_pkg::QCNT_W-1:0]  count_q;
	logic                        push;

	// classify: unknown modes and out-of-range resources become no-ops
	always_comb begin
		item_in.resource    = resource;
		item_in.is_texture  = is_texture;
		item_in.layout      = layout;
		item_in.stage_mask  = stage_mask;
		item_in.access_mask = access_mask;
		item_in.is_write    = is_write;
		if (32'(resource) >= rbt_pkg::MAX_RESOURCES) begin
			item_in.op = rbt_pkg::OP_NOP;
		end else begin
			case (mode)
				rbt_pkg::MODE_DECLARE: item_in.op = rbt_pkg::OP_DECLARE;
				rbt_pkg::MODE_ACCESS:  item_in.op = rbt_pkg::OP_ACCESS;
				rbt_pkg::MODE_READ:    item_in.op = rbt_pkg::OP_READ;
				default:               item_in.op = rbt_pkg::OP_NOP;
			endcase
		end
	end

	// queue handshake
	assign in_stall = (count_q == rbt_pkg::QCNT_W'(rbt_pkg::QUEUE_DEPTH));
	assign push     = in_valid && !in_stall;
	assign q_valid  = (count_q != '0);
	assign q_item   = q_mem_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= item_in;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, q_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: src/rbt_back.sv
// back end: resource table read-modify-write and registered result word
`default_nettype none

module rbt_back (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    q_valid,
	input  wire rbt_pkg::item_t    q_item,
	output logic                   q_pop,
	output logic                   out_valid,
	input  wire                    out_stall,
	output rbt_pkg::result_t       res
);

	rbt_pkg::state_t                 state_q;
	rbt_pkg::state_t                 state_d;
	rbt_pkg::entry_t                 mem [rbt_pkg::MAX_RESOURCES];
	logic [rbt_pkg::MAX_RESOURCES-1:0] valid_q;
	rbt_pkg::entry_t                 rdata_s2;
	logic                            vld_s2;
	rbt_pkg::item_t                  cur_s2;
	rbt_pkg::entry_t                 ent;
	rbt_pkg::entry_t                 wdata;
	logic                            wr_item;
	logic                            we;
	logic                            go;
	logic                            in_exec;
	logic [rbt_pkg::IDX_W-1:0]       rd_addr;
	logic [rbt_pkg::IDX_W-1:0]       wr_addr;
	logic [rbt_pkg::LAYOUT_W-1:0]    wanted;
	logic                            changes;
	logic                            hazard;
	rbt_pkg::result_t                res_d;
	rbt_pkg::result_t                res_q;
	logic                            out_valid_q;

	assign rd_addr = rbt_pkg::IDX_W'(q_item.resource);
	assign wr_addr = rbt_pkg::IDX_W'(cur_s2.resource);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rbt_pkg::ST_IDLE: if (q_valid) state_d = rbt_pkg::ST_EXEC;
			rbt_pkg::ST_EXEC: if (go) state_d = rbt_pkg::ST_IDLE;
			default:          state_d = rbt_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		q_pop   = 1'b0;
		in_exec = 1'b0;
		case (state_q)
			rbt_pkg::ST_IDLE: q_pop = q_valid;
			rbt_pkg::ST_EXEC: in_exec = 1'b1;
			default: begin
				q_pop   = 1'b0;
				in_exec = 1'b0;
			end
		endcase
	end

	// result register free or draining this cycle
	assign go = in_exec && (!out_valid_q || !out_stall);
	assign we = go && wr_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rbt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// table memory with registered read
	always_ff @(posedge clk) begin
		if (q_pop) begin
			rdata_s2 <= mem[rd_addr];
			cur_s2   <= q_item;
		end
		if (we) begin
			mem[wr_addr] <= wdata;
		end
	end

	// per-entry valid bits: an entry never written reads as all zeros
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vld_s2  <= 1'b0;
		end else begin
			if (q_pop) begin
				vld_s2 <= valid_q[rd_addr];
			end
			if (we) begin
				valid_q[wr_addr] <= 1'b1;
			end
		end
	end

	assign ent = vld_s2 ? rdata_s2 : '0;

	// access classification
	assign wanted  = ent.texture_kind ? cur_s2.layout : rbt_pkg::LAYOUT_UNDEFINED;
	assign changes = ent.texture_kind && (wanted != ent.cur_layout);
	assign hazard  = ent.was_written || cur_s2.is_write;

	// entry update and result word
	always_comb begin
		wdata   = ent;
		wr_item = 1'b0;
		res_d   = '0;
		case (cur_s2.op)
			rbt_pkg::OP_DECLARE: begin
				wr_item            = 1'b1;
				wdata.last_stage   = rbt_pkg::STAGE_NONE;
				wdata.last_access  = rbt_pkg::ACCESS_NONE;
				wdata.cur_layout   = cur_s2.layout;
				wdata.was_written  = 1'b0;
				wdata.texture_kind = cur_s2.is_texture;
			end
			rbt_pkg::OP_ACCESS: begin
				wr_item = 1'b1;
				if (!changes && !hazard) begin
					wdata.last_stage  = ent.last_stage | cur_s2.stage_mask;
					wdata.last_access = ent.last_access | cur_s2.access_mask;
				end else begin
					res_d.barrier_needed   = 1'b1;
					res_d.barrier_resource = cur_s2.resource;
					res_d.src_stage        = (ent.last_stage != rbt_pkg::STAGE_NONE) ?
					                         ent.last_stage : rbt_pkg::STAGE_TOP_OF_PIPE;
					res_d.dst_stage        = cur_s2.stage_mask;
					res_d.src_access       = ent.last_access;
					res_d.dst_access       = cur_s2.access_mask;
					res_d.old_layout       = ent.cur_layout;
					res_d.new_layout       = wanted;
					wdata.last_stage       = cur_s2.stage_mask;
					wdata.last_access      = cur_s2.access_mask;
					wdata.cur_layout       = wanted;
					wdata.was_written      = cur_s2.is_write;
				end
			end
			rbt_pkg::OP_READ: begin
				res_d.final_layout = ent.cur_layout;
			end
			default: begin
				wr_item = 1'b0;
			end
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			res_q <= res_d;
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

	// a word is taken from the queue only when one is there and the back is idle
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (q_valid && state_q == rbt_pkg::ST_IDLE))
		else $error("queue popped while busy or empty");

	// finishing a word always leaves a result waiting
	a_go_result: assert property (@(posedge clk) disable iff (!arst_n)
		go |=> out_valid_q)
		else $error("finished word produced no result");

	// a barrier never carries an empty source stage
	a_src_stage: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.barrier_needed) |-> (res_q.src_stage != rbt_pkg::STAGE_NONE))
		else $error("barrier with empty source stage");

	// a barrier and a final layout never share a result
	a_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.barrier_needed) |->
		(res_q.final_layout == rbt_pkg::LAYOUT_UNDEFINED))
		else $error("barrier result carries a final layout");

	// the table is only written while finishing a word
	a_we_exec: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q == rbt_pkg::ST_EXEC))
		else $error("table written outside execution");

endmodule

`default_nettype wire
